@@ rtl/mlpq_pkg.sv @@
package mlpq_pkg;

    // Field widths fixed by the request and response formats
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned TOTAL_W = 9;

    // Request action codes
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BADLEVEL = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_action                    action;
        logic signed [VALUE_W-1:0]  item_value;
        logic [LEVEL_W-1:0]         level;
    } t_req;

    typedef struct packed {
        t_status                    status;
        logic                       head_valid;
        logic signed [VALUE_W-1:0]  head_value;
        logic [LEVEL_W-1:0]         head_level;
        logic [COUNT_W-1:0]         level_count;
        logic [TOTAL_W-1:0]         total_count;
    } t_rsp;

endpackage

@@ rtl/mlpq_if.sv @@
// Request channel into the queue
interface mlpq_req_if;
    import mlpq_pkg::*;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Response channel out of the queue
interface mlpq_rsp_if;
    import mlpq_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/multilevel_priority_fifo.sv @@
// Channel   Dir   Handshake            Payload
// i_req     in    valid / ready        action, item_value, level
// o_rsp     out   valid / ready        status, head_valid, head_value, head_level,
//                                      level_count, total_count
//
// One request per cycle unless a response waits with o_rsp.ready low; each response
// appears in the cycle after its request is taken. The entry memory has separate write
// and read ports, read with registered data at the edge that updates the pointers.
// Reset (synchronous, i_rst_n low) empties every level; no memory clear is needed.
// A response waiting in the output register blocks a new request only while
// o_rsp.ready is low; when it is taken, a new request is accepted in the same cycle.
module multilevel_priority_fifo #(
    parameter int LEVELS      = 4,
    parameter int LEVEL_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlpq_req_if.sink    i_req,
    mlpq_rsp_if.source  o_rsp
);
    import mlpq_pkg::*;

    localparam int LW        = $clog2(LEVELS);
    localparam int DW        = $clog2(LEVEL_DEPTH);
    localparam int FW        = $clog2(LEVEL_DEPTH + 1);
    localparam int TW        = $clog2(LEVELS * LEVEL_DEPTH + 1);
    localparam int AW        = LW + DW;
    localparam int MEM_DEPTH = LEVELS * (2 ** DW);

    // Per-level ring state
    logic [DW-1:0]  r_rp   [LEVELS];
    logic [DW-1:0]  r_wp   [LEVELS];
    logic [FW-1:0]  r_fill [LEVELS];
    logic [TW-1:0]  r_total;
    logic [DW-1:0]  n_rp   [LEVELS];
    logic [DW-1:0]  n_wp   [LEVELS];
    logic [FW-1:0]  n_fill [LEVELS];
    logic [TW-1:0]  n_total;

    // Entry memory and its registered read data
    logic [VALUE_W-1:0] r_mem [MEM_DEPTH];
    logic [VALUE_W-1:0] r_head_value;

    // Output register
    logic               r_out_valid;
    t_rsp               r_rsp;

    logic               w_accept;
    logic               w_lvl_ok;
    logic [LW-1:0]      w_lvl;
    logic [LW-1:0]      w_top_b;
    logic               w_any_b;
    logic [LW-1:0]      w_top_a;
    logic               w_any_a;
    t_status            w_status;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [AW-1:0]      w_rd_addr;
    logic [COUNT_W-1:0] w_level_count;

    function automatic logic [DW-1:0] f_next(input logic [DW-1:0] p);
        f_next = (p == DW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Handshake: the output register frees up when its response is taken
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_lvl_ok = ({1'b0, i_req.data.level} < (LEVEL_W + 1)'(LEVELS));
    assign w_lvl    = i_req.data.level[LW-1:0];

    // Highest non-empty level before the request
    always_comb begin
        w_top_b = '0;
        w_any_b = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            if (r_fill[l] != '0) begin
                w_top_b = LW'(l);
                w_any_b = 1'b1;
            end
        end
    end

    // Next state of the level rings
    always_comb begin
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_fill    = r_fill;
        n_total   = r_total;
        w_status  = ST_OK;
        w_wr_en   = 1'b0;
        w_wr_addr = {w_lvl, r_wp[w_lvl]};
        unique case (i_req.data.action)
            ACT_INSERT: begin
                if (!w_lvl_ok) begin
                    w_status = ST_BADLEVEL;
                end else if (r_fill[w_lvl] >= FW'(LEVEL_DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_wr_en        = w_accept;
                    n_wp[w_lvl]    = f_next(r_wp[w_lvl]);
                    n_fill[w_lvl]  = r_fill[w_lvl] + 1'b1;
                    n_total        = r_total + 1'b1;
                end
            end
            ACT_POP: begin
                if (!w_any_b) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_rp[w_top_b]   = f_next(r_rp[w_top_b]);
                    n_fill[w_top_b] = r_fill[w_top_b] - 1'b1;
                    n_total         = r_total - 1'b1;
                end
            end
            ACT_CLEAR: begin
                for (int l = 0; l < LEVELS; l++) begin
                    n_rp[l]   = '0;
                    n_wp[l]   = '0;
                    n_fill[l] = '0;
                end
                n_total = '0;
            end
            default: begin
            end
        endcase
    end

    // Head after the request: highest non-empty level and its read slot
    always_comb begin
        w_top_a = '0;
        w_any_a = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            if (n_fill[l] != '0) begin
                w_top_a = LW'(l);
                w_any_a = 1'b1;
            end
        end
    end

    assign w_rd_addr     = {w_top_a, n_rp[w_top_a]};
    assign w_level_count = w_lvl_ok ? COUNT_W'(n_fill[w_lvl]) : '0;

    // Ring pointers, fills and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_rp[l]   <= '0;
                r_wp[l]   <= '0;
                r_fill[l] <= '0;
            end
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_rp    <= n_rp;
                r_wp    <= n_wp;
                r_fill  <= n_fill;
                r_total <= n_total;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp.status      <= w_status;
            r_rsp.head_valid  <= w_any_a;
            r_rsp.head_value  <= '0;
            r_rsp.head_level  <= w_any_a ? LEVEL_W'(w_top_a) : '0;
            r_rsp.level_count <= w_level_count;
            r_rsp.total_count <= TOTAL_W'(n_total);
        end
    end

    // Entry memory; the new head reads around a same-cycle write to its slot
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_req.data.item_value;
        end
        if (w_accept) begin
            priority if (!w_any_a) begin
                r_head_value <= '0;
            end else if (w_wr_en && (w_wr_addr == w_rd_addr)) begin
                r_head_value <= i_req.data.item_value;
            end else begin
                r_head_value <= r_mem[w_rd_addr];
            end
        end
    end

    always_comb begin
        o_rsp.data            = r_rsp;
        o_rsp.data.head_value = r_head_value;
    end
    assign o_rsp.valid = r_out_valid;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import mlpq_pkg::*;

    localparam int Q_LEVELS    = 4;
    localparam int Q_DEPTH     = 16;
    localparam int RANDOM_REQS = 1025;
    localparam int CHUNK       = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_CYCLES  = 600000;
    localparam int MAX_PRINTS  = 50;

    // Action code 3 is not a member of t_action; the queue must treat it as a no-op
    localparam t_action ACT_UNKNOWN = t_action'(2'd3);

    // Request waiting in the sender, optionally held until the queue has answered all
    typedef struct {
        t_req req;
        bit   drain_first;
    } t_pending_req;

    logic i_clk;
    logic i_rst_n;

    mlpq_req_if req_ch ();
    mlpq_rsp_if rsp_ch ();

    multilevel_priority_fifo #(
        .LEVELS      (Q_LEVELS),
        .LEVEL_DEPTH (Q_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the per-level rings
    logic signed [VALUE_W-1:0] ring_mem [Q_LEVELS][Q_DEPTH];
    int ring_rd   [Q_LEVELS];
    int ring_wr   [Q_LEVELS];
    int ring_fill [Q_LEVELS];

    t_pending_req req_backlog [$];
    t_rsp         queue_rsp_due [$];
    t_pending_req cur_req;

    int  n_reqs;
    int  n_taken;
    int  n_rsp;
    int  n_err;
    int  n_cycles;
    int  send_gap;
    int  stall_left;
    int  hold_left;
    int  holds_done;
    int  peak_total;
    int  status_hits [4];
    int  action_hits [4];
    bit  req_took;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) n_cycles <= n_cycles + 1;

    // Highest non-empty level, -1 when the whole queue is empty
    function automatic int top_level();
        int lv;
        for (lv = Q_LEVELS - 1; lv >= 0; lv--) begin
            if (ring_fill[lv] != 0) return lv;
        end
        return -1;
    endfunction

    // Apply one request to the shadow queue and build the response it should get
    function automatic t_rsp next_queue_rsp(input t_req r);
        t_rsp o;
        int   top;
        int   tot;
        int   lv;
        o = '0;
        o.status = ST_OK;
        case (r.action)
            ACT_INSERT: begin
                if (r.level >= Q_LEVELS) begin
                    o.status = ST_BADLEVEL;
                end else if (ring_fill[r.level] >= Q_DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    ring_mem[r.level][ring_wr[r.level]] = r.item_value;
                    ring_wr[r.level] = (ring_wr[r.level] + 1) % Q_DEPTH;
                    ring_fill[r.level]++;
                end
            end
            ACT_POP: begin
                top = top_level();
                if (top < 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    ring_rd[top] = (ring_rd[top] + 1) % Q_DEPTH;
                    ring_fill[top]--;
                end
            end
            ACT_CLEAR: begin
                for (lv = 0; lv < Q_LEVELS; lv++) begin
                    ring_rd[lv]   = 0;
                    ring_wr[lv]   = 0;
                    ring_fill[lv] = 0;
                end
            end
            default: ;
        endcase

        tot = 0;
        for (lv = 0; lv < Q_LEVELS; lv++) tot += ring_fill[lv];
        top = top_level();
        if (top >= 0) begin
            o.head_valid = 1'b1;
            o.head_value = ring_mem[top][ring_rd[top]];
            o.head_level = LEVEL_W'(top);
        end
        o.level_count = (r.level < Q_LEVELS) ? COUNT_W'(ring_fill[r.level]) : '0;
        o.total_count = TOTAL_W'(tot);

        status_hits[o.status]++;
        action_hits[r.action]++;
        if (tot > peak_total) peak_total = tot;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_err < MAX_PRINTS)
            $display("[%0t] response %0d, %s: got %0h, expected %0h",
                     $realtime, n_rsp, what, got, want);
        n_err++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic push_req(input t_action act, input logic [31:0] val,
                            input int lvl, input bit drain);
        t_pending_req p;
        p.req.action     = act;
        p.req.item_value = val;
        p.req.level      = LEVEL_W'(lvl);
        p.drain_first    = drain;
        req_backlog.push_back(p);
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random request biased toward filling, draining or churning the queue
    task automatic push_random(input int bias, input int fav_level, input bit drain);
        int          r;
        int          ins_pct;
        int          lvl;
        logic [31:0] val;
        t_action     act;
        ins_pct = (bias == 0) ? 78 : (bias == 1) ? 20 : 48;
        r = $urandom_range(0, 99);
        if (r < 2)                 act = ACT_CLEAR;
        else if (r < 5)            act = ACT_UNKNOWN;
        else if (r < 5 + ins_pct)  act = ACT_INSERT;
        else                       act = ACT_POP;

        r = $urandom_range(0, 99);
        if (r < 10)      lvl = $urandom_range(Q_LEVELS, 2**LEVEL_W - 1);
        else if (r < 64) lvl = fav_level;
        else             lvl = $urandom_range(0, Q_LEVELS - 1);

        case ($urandom_range(0, 39))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = 32'h0000_0000;
            3:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
        endcase
        push_req(act, val, lvl, drain);
    endtask

    // Request monitor and response checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_rsp++;
                if (queue_rsp_due.size() == 0) begin
                    report_mismatch("response with no request outstanding", 0, 0);
                end else begin
                    automatic t_rsp want = queue_rsp_due.pop_front();
                    check_field("status",      rsp_ch.data.status,      want.status);
                    check_field("head_valid",  rsp_ch.data.head_valid,  want.head_valid);
                    check_field("head_value",  rsp_ch.data.head_value,  want.head_value);
                    check_field("head_level",  rsp_ch.data.head_level,  want.head_level);
                    check_field("level_count", rsp_ch.data.level_count, want.level_count);
                    check_field("total_count", rsp_ch.data.total_count, want.total_count);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                queue_rsp_due.push_back(next_queue_rsp(req_ch.data));
                n_taken++;
                req_took = 1'b1;
            end
        end
    end

    // Request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_took) begin
            req_took = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].drain_first && queue_rsp_due.size() != 0)) begin
                cur_req = req_backlog.pop_front();
                req_ch.data  <= cur_req.req;
                req_ch.valid <= 1'b1;
                // calm window: back-to-back requests
                send_gap = ((n_cycles % 1024) < 150) ? 0 : idle_len();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-offs, counted here, while the sender keeps offering
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && n_taken >= 300) ||
                     (holds_done == 1 && n_taken >= 700)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Response ready with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = ((n_cycles % 1024) >= 100 && (n_cycles % 1024) < 250) ? 0 : idle_len();
        end
    end

    // Timeout
    initial begin
        while (n_cycles < MAX_CYCLES) @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int k;
        int bias;
        int fav;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        n_taken = 0; n_rsp = 0; n_err = 0; n_cycles = 0;
        send_gap = 0; stall_left = 0; hold_left = 0; holds_done = 0;
        peak_total = 0; req_took = 1'b0;
        bias = 0; fav = 0;
        for (k = 0; k < 4; k++) begin
            status_hits[k] = 0;
            action_hits[k] = 0;
        end
        for (k = 0; k < Q_LEVELS; k++) begin
            ring_rd[k] = 0; ring_wr[k] = 0; ring_fill[k] = 0;
        end

        // Directed: empty queue, bad levels, no-op action, filling the top level
        push_req(ACT_POP,     32'h0,         0,  1'b0);
        push_req(ACT_CLEAR,   32'h0,         15, 1'b0);
        push_req(ACT_UNKNOWN, 32'hFFFF_FFFF, 5,  1'b0);
        push_req(ACT_INSERT,  32'h7FFF_FFFF, Q_LEVELS, 1'b0);
        push_req(ACT_INSERT,  32'h8000_0000, 15, 1'b0);
        push_req(ACT_INSERT,  32'h7FFF_FFFF, Q_LEVELS - 1, 1'b0);
        push_req(ACT_INSERT,  32'h8000_0000, Q_LEVELS - 1, 1'b0);
        for (k = 2; k < Q_DEPTH; k++)
            push_req(ACT_INSERT, $urandom, Q_LEVELS - 1, 1'b0);
        push_req(ACT_INSERT,  32'h1234_5678, Q_LEVELS - 1, 1'b0);  // level full
        push_req(ACT_INSERT,  32'hFFFF_FFFF, 0, 1'b0);             // lower level waits
        push_req(ACT_POP,     32'h0,         Q_LEVELS - 1, 1'b0);
        push_req(ACT_CLEAR,   32'h0,         Q_LEVELS - 1, 1'b0);

        // Random: chunks that fill, drain or churn, some starting on an empty pipe
        for (k = 0; k < RANDOM_REQS; k++) begin
            if (k % CHUNK == 0) begin
                bias = $urandom_range(0, 2);
                fav  = $urandom_range(0, Q_LEVELS - 1);
            end
            push_random(bias, fav, (k % (5 * CHUNK)) == 0);
        end
        n_reqs = req_backlog.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_reqs || queue_rsp_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (queue_rsp_due.size() != 0)
            report_mismatch("responses never delivered", queue_rsp_due.size(), 0);

        $display("Covered %0d requests: %0d insert, %0d pop, %0d clear, %0d no-op; peak fill %0d",
                 n_taken, action_hits[ACT_INSERT], action_hits[ACT_POP],
                 action_hits[ACT_CLEAR], action_hits[ACT_UNKNOWN], peak_total);
        $display("Status ok %0d, pop on empty %0d, bad level %0d, level full %0d",
                 status_hits[ST_OK], status_hits[ST_EMPTY],
                 status_hits[ST_BADLEVEL], status_hits[ST_FULL]);
        if (n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mlpq_pkg.sv
rtl/mlpq_if.sv
rtl/multilevel_priority_fifo.sv
bench/tb_top.sv
